@@ design/ljf_pkg.sv @@
// Shared types and sizes of the longest-job-first scheduler.
// Used by ljf_cell, ljf_pick and longest_job_first_scheduler_top; depends on nothing.
package ljf_pkg;

  localparam int MAX_JOBS = 32;
  localparam int ARR_W    = 20;
  localparam int COST_W   = 16;
  localparam int TIME_W   = 24;
  localparam int SLOT_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int S_DATA_W = ((ARR_W + COST_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((COST_W + 7) / 8) * 8;

  // One stored job as it sits in a cell of the ring.
  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] slot;
    logic [ARR_W-1:0]  arr;
    logic [COST_W-1:0] cost;
  } job_t;

  // Running candidates of one scan pass.
  typedef struct packed {
    job_t early;  // earliest arrival, then load order
    job_t best;   // arrived: largest cost, then earliest arrival, then load order
  } pick_t;

endpackage

@@ design/ljf_cell.sv @@
// One cell of the job ring: holds one job and takes its neighbor's job when enabled.
// Depends on ljf_pkg.
module ljf_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          clr_i,
  input  ljf_pkg::job_t d_i,
  output ljf_pkg::job_t q_o
);

  logic                      vld_q;
  logic [ljf_pkg::SLOT_W-1:0] slot_q;
  logic [ljf_pkg::ARR_W-1:0]  arr_q;
  logic [ljf_pkg::COST_W-1:0] cost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (clr_i) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= d_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      slot_q <= d_i.slot;
      arr_q  <= d_i.arr;
      cost_q <= d_i.cost;
    end
  end

  assign q_o = '{vld: vld_q, slot: slot_q, arr: arr_q, cost: cost_q};

endmodule

@@ design/ljf_pick.sv @@
// Scan comparator: folds one job per cycle, while enabled, into the earliest and the best-arrived candidate.
// Depends on ljf_pkg.
module ljf_pick (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       start_i,
  input  ljf_pkg::job_t              job_i,
  input  logic [ljf_pkg::TIME_W-1:0] now_i,
  output ljf_pkg::pick_t             res_o
);

  ljf_pkg::job_t early_q, best_q;
  ljf_pkg::job_t early_b, best_b;
  ljf_pkg::job_t early_d, best_d;
  logic          arrived;
  logic          take_early, take_best;

  always_comb begin
    early_b = early_q;
    best_b  = best_q;
    // A new pass starts from empty candidates.
    if (start_i) begin
      early_b.vld = 1'b0;
      best_b.vld  = 1'b0;
    end

    arrived = job_i.vld && (ljf_pkg::TIME_W'(job_i.arr) <= now_i);

    take_early = job_i.vld &&
                 (!early_b.vld || (job_i.arr < early_b.arr) ||
                  ((job_i.arr == early_b.arr) && (job_i.slot < early_b.slot)));

    take_best = arrived &&
                (!best_b.vld || (job_i.cost > best_b.cost) ||
                 ((job_i.cost == best_b.cost) &&
                  ((job_i.arr < best_b.arr) ||
                   ((job_i.arr == best_b.arr) && (job_i.slot < best_b.slot)))));

    early_d = take_early ? job_i : early_b;
    best_d  = take_best  ? job_i : best_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      early_q <= '0;
      best_q  <= '0;
    end else if (en_i) begin
      early_q <= early_d;
      best_q  <= best_d;
    end
  end

  assign res_o = '{early: early_d, best: best_d};

endmodule

@@ design/longest_job_first_scheduler_top.sv @@
// Longest-job-first scheduler: a ring of MAX_JOBS cells rotates past one comparator.
// Load: one job per cycle, no result. After the last job, one warm-up pass of the ring
// finds the start time, then each result needs one full ring pass past the single
// comparator at the ring head, plus any output stall.
// Reset (async, active low) empties the ring, clears counters, time and the output.
// Depends on ljf_pkg, ljf_cell and ljf_pick.
module longest_job_first_scheduler_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [19:0] arrival_time, [35:20] job_cost, upper bits zero
  input  logic [ljf_pkg::S_DATA_W-1:0] s_axis_tdata_i,
  input  logic                         s_axis_tlast_i,   // last_job
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [15:0] scheduled_cost
  output logic [ljf_pkg::M_DATA_W-1:0] m_axis_tdata_o,
  output logic                         m_axis_tlast_o    // final_result
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [ljf_pkg::CNT_W-1:0]    load_cnt_q, load_cnt_d;
  logic [ljf_pkg::CNT_W-1:0]    rem_q, rem_d;
  logic [ljf_pkg::SLOT_W-1:0]   pass_cnt_q, pass_cnt_d;
  logic [ljf_pkg::TIME_W-1:0]   time_q, time_d;
  logic                         kill_v_q, kill_v_d;
  logic [ljf_pkg::SLOT_W-1:0]   kill_slot_q, kill_slot_d;
  logic                         out_v_q, out_v_d;
  logic [ljf_pkg::COST_W-1:0]   out_cost_q, out_cost_d;
  logic                         out_last_q, out_last_d;

  ljf_pkg::job_t                cell_q [ljf_pkg::MAX_JOBS];
  ljf_pkg::job_t                cell_d [ljf_pkg::MAX_JOBS];
  ljf_pkg::job_t                head, new_job, sel;
  ljf_pkg::pick_t               pick;
  logic                         in_xfer, store, chain_en, chain_clr;
  logic                         scanning, pass_last, out_free, advance;
  logic [ljf_pkg::TIME_W-1:0]   sel_arr, start_t;

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign store           = in_xfer && (load_cnt_q < ljf_pkg::CNT_W'(ljf_pkg::MAX_JOBS));

  assign scanning  = (state_q == ST_INIT) || (state_q == ST_SCAN);
  assign pass_last = (pass_cnt_q == ljf_pkg::SLOT_W'(ljf_pkg::MAX_JOBS - 1));
  assign out_free  = !out_v_q || m_axis_tready_i;
  // Hold the whole ring when a result is due but the output is still full.
  assign advance   = scanning && !(state_q == ST_SCAN && pass_last && !out_free);

  // Drop the job chosen in the previous pass as it comes round the head.
  always_comb begin
    head = cell_q[ljf_pkg::MAX_JOBS-1];
    if (kill_v_q && (head.slot == kill_slot_q)) begin
      head.vld = 1'b0;
    end
  end

  assign new_job = '{vld:  1'b1,
                     slot: ljf_pkg::SLOT_W'(load_cnt_q),
                     arr:  s_axis_tdata_i[ljf_pkg::ARR_W-1:0],
                     cost: s_axis_tdata_i[ljf_pkg::ARR_W +: ljf_pkg::COST_W]};

  // Shift new jobs in at the tail while loading, rotate while scanning.
  assign cell_d[0] = scanning ? head : new_job;
  assign chain_en  = store || advance;

  for (genvar gi = 0; gi < ljf_pkg::MAX_JOBS; gi++) begin : g_ring
    if (gi > 0) begin : g_link
      assign cell_d[gi] = cell_q[gi-1];
    end
    ljf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (chain_en),
      .clr_i  (chain_clr),
      .d_i    (cell_d[gi]),
      .q_o    (cell_q[gi])
    );
  end

  ljf_pick u_pick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .start_i (pass_cnt_q == '0),
    .job_i   (head),
    .now_i   (time_q),
    .res_o   (pick)
  );

  // An arrived job wins; with none arrived, take the earliest pending one.
  assign sel     = pick.best.vld ? pick.best : pick.early;
  assign sel_arr = ljf_pkg::TIME_W'(sel.arr);
  assign start_t = (sel_arr > time_q) ? sel_arr : time_q;

  always_comb begin
    state_d     = state_q;
    load_cnt_d  = load_cnt_q;
    rem_d       = rem_q;
    pass_cnt_d  = pass_cnt_q;
    time_d      = time_q;
    kill_v_d    = kill_v_q;
    kill_slot_d = kill_slot_q;
    out_v_d     = out_v_q && !m_axis_tready_i;
    out_cost_d  = out_cost_q;
    out_last_d  = out_last_q;
    chain_clr   = 1'b0;

    if (advance) begin
      pass_cnt_d = pass_last ? '0 : pass_cnt_q + 1'b1;
    end

    unique case (state_q)
      ST_LOAD: begin
        if (store) begin
          load_cnt_d = load_cnt_q + 1'b1;
        end
        if (in_xfer && s_axis_tlast_i) begin
          rem_d      = store ? load_cnt_q + 1'b1 : load_cnt_q;
          pass_cnt_d = '0;
          kill_v_d   = 1'b0;
          state_d    = ST_INIT;
        end
      end
      ST_INIT: begin
        // Warm-up pass: the clock starts at the earliest arrival.
        if (pass_last) begin
          time_d  = ljf_pkg::TIME_W'(pick.early.arr);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pass_last && advance) begin
          time_d      = start_t + ljf_pkg::TIME_W'(sel.cost);
          kill_v_d    = 1'b1;
          kill_slot_d = sel.slot;
          out_v_d     = 1'b1;
          out_cost_d  = sel.cost;
          out_last_d  = (rem_q == ljf_pkg::CNT_W'(1));
          rem_d       = rem_q - 1'b1;
          if (rem_q == ljf_pkg::CNT_W'(1)) begin
            // Schedule done: empty the store for the next batch.
            chain_clr  = 1'b1;
            load_cnt_d = '0;
            kill_v_d   = 1'b0;
            state_d    = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      rem_q      <= '0;
      pass_cnt_q <= '0;
      time_q     <= '0;
      kill_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      rem_q      <= rem_d;
      pass_cnt_q <= pass_cnt_d;
      time_q     <= time_d;
      kill_v_q   <= kill_v_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kill_slot_q <= kill_slot_d;
    out_cost_q  <= out_cost_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = ljf_pkg::M_DATA_W'(out_cost_q);
  assign m_axis_tlast_o  = out_last_q;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench of longest_job_first_scheduler_top: batches of jobs go in,
// every emitted cost and final flag is compared with an in-bench schedule replay.
// Depends on ljf_pkg and the scheduler RTL only.
module tb;

  localparam int MAX_JOBS = ljf_pkg::MAX_JOBS;
  localparam int ARR_W    = ljf_pkg::ARR_W;
  localparam int COST_W   = ljf_pkg::COST_W;
  localparam int TIME_W   = ljf_pkg::TIME_W;
  localparam int S_DATA_W = ljf_pkg::S_DATA_W;
  localparam int M_DATA_W = ljf_pkg::M_DATA_W;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                s_valid = 1'b0;
  logic [S_DATA_W-1:0] s_data  = '0;
  logic                s_last  = 1'b0;
  logic                m_ready = 1'b0;

  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [M_DATA_W-1:0] m_axis_tdata_o;
  logic                m_axis_tlast_o;

  longest_job_first_scheduler_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),     // [19:0] arrival_time, [35:20] job_cost
    .s_axis_tlast_i  (s_last),     // last_job
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // [15:0] scheduled_cost
    .m_axis_tlast_o  (m_axis_tlast_o)   // final_result
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // One expected output transfer of the schedule.
  typedef struct {
    logic [COST_W-1:0] cost;
    logic              last_flag;
  } sched_entry_t;

  sched_entry_t sched_order_q[$];

  // Shadow of the job store and the schedule clock.
  logic [ARR_W-1:0]  job_arr_m  [MAX_JOBS];
  logic [COST_W-1:0] job_cost_m [MAX_JOBS];
  int                jobs_held;
  logic [TIME_W-1:0] clock_now;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_len       = 0;
  logic hold_on        = 1'b0;
  event hold_start;

  int mismatch_cnt = 0;
  int jobs_sent    = 0;
  int jobs_dropped = 0;
  int batches_done = 0;
  int results_seen = 0;

  // Earliest-arriving waiting slot, lowest slot on ties; -1 when none waits.
  function automatic int earliest_slot(input logic [MAX_JOBS-1:0] waiting);
    int e;
    e = -1;
    for (int s = 0; s < jobs_held; s++)
      if (waiting[s] && (e < 0 || job_arr_m[s] < job_arr_m[e])) e = s;
    return e;
  endfunction

  // Longest arrived job; ties to earlier arrival, then slot. Idle clock: earliest job.
  function automatic int next_slot(input logic [MAX_JOBS-1:0] waiting,
                                   input logic [TIME_W-1:0] now);
    int b;
    b = earliest_slot(waiting);
    if (b < 0 || job_arr_m[b] > now) return b;
    for (int s = 0; s < jobs_held; s++) begin
      if (!waiting[s] || job_arr_m[s] > now) continue;
      if (job_cost_m[s] > job_cost_m[b] ||
          (job_cost_m[s] == job_cost_m[b] && job_arr_m[s] < job_arr_m[b])) b = s;
    end
    return b;
  endfunction

  // Replay the held batch and queue its costs in execution order.
  task automatic replay_batch();
    logic [MAX_JOBS-1:0] waiting;
    sched_entry_t        entry;
    int                  pick;
    waiting = '0;
    for (int i = 0; i < jobs_held; i++) waiting[i] = 1'b1;
    pick = earliest_slot(waiting);
    if (pick >= 0) clock_now = TIME_W'(job_arr_m[pick]);
    pick = next_slot(waiting, clock_now);
    while (pick >= 0) begin
      if (job_arr_m[pick] > clock_now) clock_now = TIME_W'(job_arr_m[pick]);
      clock_now       = clock_now + TIME_W'(job_cost_m[pick]);
      waiting[pick]   = 1'b0;
      entry.cost      = job_cost_m[pick];
      entry.last_flag = (waiting == '0);
      sched_order_q.push_back(entry);
      pick = next_slot(waiting, clock_now);
    end
    jobs_held = 0;
    batches_done++;
  endtask

  task automatic note_job(input logic [ARR_W-1:0] arr, input logic [COST_W-1:0] cost,
                          input logic last);
    jobs_sent++;
    if (jobs_held < MAX_JOBS) begin
      job_arr_m[jobs_held]  = arr;
      job_cost_m[jobs_held] = cost;
      jobs_held++;
    end else begin
      jobs_dropped++;
    end
    if (last) replay_batch();
  endtask

  // Offer one job, idling first at random, and hold it until the transfer.
  task automatic send_job(input logic [ARR_W-1:0] arr, input logic [COST_W-1:0] cost,
                          input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= S_DATA_W'({cost, arr});
    s_last  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    note_job(arr, cost, last);
  endtask

  // Random batch; the content style decides how often ties and idle gaps occur.
  task automatic send_batch(input int len);
    logic [ARR_W-1:0]  base, arr;
    logic [COST_W-1:0] cost;
    int                style;
    style = $urandom_range(3);
    base  = ARR_W'($urandom);
    for (int k = 0; k < len; k++) begin
      case (style)
        0: begin
          arr  = ARR_W'($urandom);
          cost = COST_W'($urandom);
        end
        1: begin  // tight cluster, few cost values: many ties
          arr  = base + ARR_W'($urandom_range(63));
          cost = COST_W'($urandom_range(15));
        end
        2: begin  // spread arrivals, short jobs: clock runs dry between jobs
          arr  = base + ARR_W'(k * 50 + $urandom_range(20));
          cost = COST_W'($urandom_range(40));
        end
        default: begin  // cost extremes around a common instant
          arr = base + ARR_W'($urandom_range(3));
          case ($urandom_range(3))
            0:       cost = '0;
            1:       cost = 16'd1;
            2:       cost = 16'h8000;
            default: cost = '1;
          endcase
        end
      endcase
      send_job(arr, cost, k == len - 1);
    end
  endtask

  // Drop the input valid and let every queued result come out.
  task automatic drain_results();
    s_valid <= 1'b0;
    while (sched_order_q.size() != 0) @(posedge clk_i);
    repeat (2 * MAX_JOBS + 8) @(posedge clk_i);
  endtask

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  // Receiver hold-off: keep tready low for a counted stretch of cycles.
  initial begin
    forever begin
      @(hold_start);
      hold_on = 1'b1;
      repeat (hold_len) @(posedge clk_i);
      hold_on = 1'b0;
    end
  end

  // Output side: check each transfer, then pick the next ready value.
  always @(posedge clk_i) begin
    sched_entry_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      results_seen++;
      if (sched_order_q.size() == 0) begin
        flag_mismatch("unexpected result cost", -1, int'(m_axis_tdata_o[COST_W-1:0]));
      end else begin
        want = sched_order_q.pop_front();
        if (m_axis_tdata_o[COST_W-1:0] !== want.cost)
          flag_mismatch("scheduled_cost", int'(want.cost), int'(m_axis_tdata_o[COST_W-1:0]));
        if (m_axis_tlast_o !== want.last_flag)
          flag_mismatch("final_result", int'(want.last_flag), int'(m_axis_tlast_o));
      end
    end
    if (hold_on) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Field extremes, single-job batches.
  task automatic test_single_jobs();
    send_job('0, '0, 1'b1);
    send_job('1, '1, 1'b1);
    drain_results();
  endtask

  // Tie rules, late arrivals and a start clock set by a later-loaded job.
  task automatic test_tie_breaks();
    send_job(20'd100,  16'd7,     1'b0);
    send_job(20'd100,  16'd7,     1'b0);
    send_job(20'd90,   16'd7,     1'b0);
    send_job(20'd90,   16'd3,     1'b0);
    send_job(20'd5000, 16'hFFFF,  1'b0);
    send_job(20'd95,   16'd7,     1'b1);
    send_job(20'd800,  16'd2,     1'b0);
    send_job(20'd300,  16'd1,     1'b0);
    send_job(20'd300,  16'd9,     1'b1);
    drain_results();
  endtask

  // Hold the output off while an overfull batch and a second one are offered.
  task automatic test_output_holdoff();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len       = 400;
    -> hold_start;
    send_batch(MAX_JOBS + 3);
    send_batch(5);
    drain_results();
  endtask

  task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                     input int items);
    int sent, len;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(11) == 0) ? $urandom_range(24, MAX_JOBS + 4)
                                      : $urandom_range(1, 8);
      send_batch(len);
      sent += len;
    end
    drain_results();
  endtask

  initial begin
    jobs_held = 0;
    clock_now = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_jobs();
    test_tie_breaks();
    test_output_holdoff();
    test_random_traffic(0,  0,  70);
    test_random_traffic(55, 0,  70);
    test_random_traffic(0,  55, 70);
    test_random_traffic(38, 38, 70);

    $display("Sent %0d jobs in %0d batches (%0d dropped at a full store), checked %0d results",
             jobs_sent, batches_done, jobs_dropped, results_seen);
    $display("Idle mixes: none, input gaps, output stalls, both; one long output hold-off");
    if (mismatch_cnt == 0 && sched_order_q.size() == 0) begin
      $display("[longest_job_first_scheduler_top] OK");
    end else begin
      $display("%0d mismatches, %0d results still missing", mismatch_cnt,
               sched_order_q.size());
      $display("[longest_job_first_scheduler_top] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", sched_order_q.size());
    $display("[longest_job_first_scheduler_top] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
design/ljf_pkg.sv
design/ljf_cell.sv
design/ljf_pick.sv
design/longest_job_first_scheduler_top.sv
tb/sv/tb.sv
